>>> rtl/sddc_pkg.sv
// sddc_pkg: shared types, register indexes and reset values for the
// sensor disconnect drift check. No dependencies.
`default_nettype none

package sddc_pkg;

  localparam int unsigned SAMPLE_COUNT_DEF = 20;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_LO   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_HI   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FINAL_LO  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FINAL_HI  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_EARLY_LIM = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RISE_LIM  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_JUMP_SIZE = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_JUMP_LIM  = 3'd7;

  // reset values
  localparam logic [7:0] INIT_LO_RST   = 8'd60;
  localparam logic [7:0] INIT_HI_RST   = 8'd100;
  localparam logic [7:0] FINAL_LO_RST  = 8'd83;
  localparam logic [7:0] FINAL_HI_RST  = 8'd88;
  localparam logic [7:0] EARLY_LIM_RST = 8'd2;
  localparam logic [7:0] RISE_LIM_RST  = 8'd5;
  localparam logic [7:0] JUMP_SIZE_RST = 8'd2;
  localparam logic [5:0] JUMP_LIM_RST  = 6'd5;

  localparam logic [4:0] TALLY_MAX = 5'd31;

  typedef struct packed {
    logic [7:0] init_lo;
    logic [7:0] init_hi;
    logic [7:0] final_lo;
    logic [7:0] final_hi;
    logic [7:0] early_lim;
    logic [7:0] rise_lim;
    logic [7:0] jump_size;
    logic [5:0] jump_lim;
  } cfg_t;

  // run state apart from the sample index
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] prev;
    logic [4:0] tally;
    logic       early;
    logic [2:0] sensor;
  } run_t;

  typedef struct packed {
    logic       fire;
    logic [2:0] sensor;
    logic [4:0] flags;
    logic [2:0] count;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/sensor_disconnect_drift_check.sv
// sensor_disconnect_drift_check: floating-input check over a run of readings.
// Depends on sddc_pkg and sddc_eval.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[7:0] sample, tuser[0] run_start,
//                                           tuser[3:1] sensor_id
//  m_axis    out  m_axis_tvalid/tready      tdata[4:0] test_flags,
//                                           tdata[7:5] evidence_count,
//                                           tuser[2:0] checked_sensor
//  cfg       in   cfg_we_i                  cfg_addr_i index, cfg_data_i value
//
// one item per cycle sustained while the output is not stalled; an item sits
// in the input register after its accepting edge, is evaluated, and its result
// (on the last reading of a run) lands in the output register, which drives
// m_axis_tvalid; the result is taken from there on m_axis_tready.
// rst_ni clears the run state, both valid flags and loads register defaults.
// a stalled output only holds up the pipe when the output register is full
// and not taken; the input register then holds its item.
`default_nettype none

module sensor_disconnect_drift_check #(
  parameter int unsigned SAMPLE_COUNT = sddc_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [sddc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [sddc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // sample
  input  logic [3:0]                      s_axis_tuser,   // run_start, sensor_id
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // test_flags, evidence_count
  output logic [2:0]                      m_axis_tuser    // checked_sensor
);

  localparam int unsigned IDX_W = $clog2(SAMPLE_COUNT);

  // config registers
  sddc_pkg::cfg_t cfg_q;

  // input register
  logic       in_vld_q;
  logic [7:0] in_sample_q;
  logic       in_start_q;
  logic [2:0] in_id_q;

  // run state
  sddc_pkg::run_t   run_q, run_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // output register
  logic           out_vld_q, out_vld_d;
  sddc_pkg::res_t res_d;
  logic [4:0]     out_flags_q;
  logic [2:0]     out_count_q;
  logic [2:0]     out_sensor_q;

  logic adv;
  logic take;

  // evaluate the held item when the output register can take a result
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  sddc_eval #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .IDX_W        (IDX_W)
  ) u_eval (
    .cfg_i    (cfg_q),
    .run_i    (run_q),
    .idx_i    (idx_q),
    .sample_i (in_sample_q),
    .start_i  (in_start_q),
    .id_i     (in_id_q),
    .run_o    (run_d),
    .idx_o    (idx_d),
    .res_o    (res_d)
  );

  always_comb begin
    out_vld_d = out_vld_q && !m_axis_tready;
    if (adv && res_d.fire) begin
      out_vld_d = 1'b1;
    end
  end

  // config writes, one register for each address code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_lo   <= sddc_pkg::INIT_LO_RST;
      cfg_q.init_hi   <= sddc_pkg::INIT_HI_RST;
      cfg_q.final_lo  <= sddc_pkg::FINAL_LO_RST;
      cfg_q.final_hi  <= sddc_pkg::FINAL_HI_RST;
      cfg_q.early_lim <= sddc_pkg::EARLY_LIM_RST;
      cfg_q.rise_lim  <= sddc_pkg::RISE_LIM_RST;
      cfg_q.jump_size <= sddc_pkg::JUMP_SIZE_RST;
      cfg_q.jump_lim  <= sddc_pkg::JUMP_LIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        sddc_pkg::REG_INIT_LO:   cfg_q.init_lo   <= cfg_data_i;
        sddc_pkg::REG_INIT_HI:   cfg_q.init_hi   <= cfg_data_i;
        sddc_pkg::REG_FINAL_LO:  cfg_q.final_lo  <= cfg_data_i;
        sddc_pkg::REG_FINAL_HI:  cfg_q.final_hi  <= cfg_data_i;
        sddc_pkg::REG_EARLY_LIM: cfg_q.early_lim <= cfg_data_i;
        sddc_pkg::REG_RISE_LIM:  cfg_q.rise_lim  <= cfg_data_i;
        sddc_pkg::REG_JUMP_SIZE: cfg_q.jump_size <= cfg_data_i;
        sddc_pkg::REG_JUMP_LIM:  cfg_q.jump_lim  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      run_q     <= '0;
      idx_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        run_q <= run_d;
        idx_q <= idx_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_sample_q <= s_axis_tdata;
      in_start_q  <= s_axis_tuser[0];
      in_id_q     <= s_axis_tuser[3:1];
    end
    if (adv && res_d.fire) begin
      out_flags_q  <= res_d.flags;
      out_count_q  <= res_d.count;
      out_sensor_q <= res_d.sensor;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_count_q, out_flags_q};
  assign m_axis_tuser  = out_sensor_q;

endmodule

`default_nettype wire

>>> rtl/sddc_eval.sv
// sddc_eval: per-item evaluation of one reading against the run state.
// Depends on sddc_pkg.
`default_nettype none

module sddc_eval #(
  parameter int unsigned SAMPLE_COUNT = sddc_pkg::SAMPLE_COUNT_DEF,
  parameter int unsigned IDX_W        = $clog2(SAMPLE_COUNT)
) (
  input  sddc_pkg::cfg_t   cfg_i,
  input  sddc_pkg::run_t   run_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [7:0]       sample_i,
  input  logic             start_i,
  input  logic [2:0]       id_i,
  output sddc_pkg::run_t   run_o,
  output logic [IDX_W-1:0] idx_o,
  output sddc_pkg::res_t   res_o
);

  logic       up, down, early_now, rise, init_ok, final_ok, jumps_hi, last;
  logic [5:0] tally_sum;
  logic [4:0] tally_new;
  logic       early_new;
  logic [4:0] flags;

  // differences done as unsigned sums, s - p >= j  <=>  s >= p + j
  assign up   = {1'b0, sample_i} >= ({1'b0, run_i.prev} + {1'b0, cfg_i.jump_size});
  assign down = {1'b0, run_i.prev} >= ({1'b0, sample_i} + {1'b0, cfg_i.jump_size});
  assign early_now = {1'b0, sample_i} >= ({1'b0, run_i.first} + {1'b0, cfg_i.early_lim});
  assign rise      = {1'b0, sample_i} >= ({1'b0, run_i.first} + {1'b0, cfg_i.rise_lim});

  assign tally_sum = {1'b0, run_i.tally} + {5'd0, up} + {5'd0, down};
  assign tally_new = tally_sum[5] ? sddc_pkg::TALLY_MAX : tally_sum[4:0];

  assign early_new = (idx_i == IDX_W'(1)) ? early_now : run_i.early;

  assign init_ok  = (run_i.first > cfg_i.init_lo) && (run_i.first < cfg_i.init_hi);
  assign final_ok = (sample_i > cfg_i.final_lo) && (sample_i < cfg_i.final_hi);
  assign jumps_hi = {1'b0, tally_new} > cfg_i.jump_lim;

  assign flags = {jumps_hi, final_ok, rise, early_new, init_ok};
  assign last  = idx_i == IDX_W'(SAMPLE_COUNT - 1);

  always_comb begin
    run_o        = run_i;
    idx_o        = idx_i;
    res_o.fire   = 1'b0;
    res_o.sensor = run_i.sensor;
    res_o.flags  = flags;
    res_o.count  = {2'd0, flags[0]} + {2'd0, flags[1]} + {2'd0, flags[2]}
                 + {2'd0, flags[3]} + {2'd0, flags[4]};
    if (start_i) begin
      run_o.first  = sample_i;
      run_o.prev   = sample_i;
      run_o.tally  = '0;
      run_o.early  = 1'b0;
      run_o.sensor = id_i;
      idx_o        = IDX_W'(1);
    end else if (idx_i != '0) begin
      run_o.prev  = sample_i;
      run_o.tally = tally_new;
      run_o.early = early_new;
      if (last) begin
        idx_o      = '0;
        res_o.fire = 1'b1;
      end else begin
        idx_o = idx_i + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking bench for the sensor disconnect drift check.
// Needs sddc_pkg, sddc_eval and the sensor_disconnect_drift_check rtl, nothing else.
// Runs a scripted opening, then randomized check runs under changing bounds.
`timescale 1ns / 1ps

module tb_top;

  localparam int RUN_LEN      = sddc_pkg::SAMPLE_COUNT_DEF;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 6;     // pipe depth plus margin
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int RUNS_PER_SET = 8;

  // test flag bit positions in the result
  localparam int FLAG_INIT  = 0;
  localparam int FLAG_EARLY = 1;
  localparam int FLAG_RISE  = 2;
  localparam int FLAG_FINAL = 3;
  localparam int FLAG_JUMPS = 4;

  typedef struct packed {
    logic [2:0] sensor;
    logic [4:0] flags;
    logic [2:0] count;
  } verdict_t;

  // one row of the opening script; typed rows carry their verdict by hand
  typedef struct {
    logic [7:0] sample;
    logic       start;
    logic [2:0] sensor;
    bit         typed;
    verdict_t   want;
  } script_row_t;

  // ---------------------------------------------------------------- dut ports
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [sddc_pkg::CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [sddc_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = '0;   // sample
  logic [3:0]                      s_axis_tuser  = '0;   // run_start, sensor_id
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [7:0]                      m_axis_tdata;   // test_flags, evidence_count
  logic [2:0]                      m_axis_tuser;   // checked_sensor

  sensor_disconnect_drift_check #(
    .SAMPLE_COUNT(RUN_LEN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ------------------------------------------------------ bench-side state
  // shadow of the bound registers, bit 7:6 of the jump limit already dropped
  logic [7:0] reg_copy [0:7] = '{sddc_pkg::INIT_LO_RST, sddc_pkg::INIT_HI_RST,
                                 sddc_pkg::FINAL_LO_RST, sddc_pkg::FINAL_HI_RST,
                                 sddc_pkg::EARLY_LIM_RST, sddc_pkg::RISE_LIM_RST,
                                 sddc_pkg::JUMP_SIZE_RST,
                                 {2'b00, sddc_pkg::JUMP_LIM_RST}};
  logic [7:0] next_cfg [0:7];

  // shadow of the run being checked; run_pos 0 means no run open
  int         run_pos    = 0;
  logic [7:0] run_first  = '0;
  logic [7:0] run_prev   = '0;
  logic [4:0] run_tally  = '0;
  logic       run_early  = 1'b0;
  logic [2:0] run_sensor = '0;

  verdict_t pending_verdicts [$];
  int       err_count  = 0;
  int       run_items  = 0;     // items sent inside check runs
  bit       calm       = 1'b0;  // no idling on either side
  bit       hold_req   = 1'b0;  // asks the receiver for one long hold-off
  int       hold_left  = 0;
  int       stall_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic logic [7:0] clip(input int x);
    return (x < 0) ? 8'd0 : (x > 255) ? 8'd255 : 8'(x);
  endfunction

  // uniform offset in -w..w
  function automatic int jitter(input int w);
    return int'($urandom_range(0, 2 * w)) - w;
  endfunction

  // advances the shadow run by one reading; returns 1 when the run closes
  function automatic bit assess_reading(input logic [7:0] s, input logic st,
                                        input logic [2:0] id, output verdict_t v);
    int cur;
    int first_i;
    int jump_i;
    v       = '0;
    cur     = int'(s);
    first_i = int'(run_first);
    jump_i  = int'(reg_copy[sddc_pkg::REG_JUMP_SIZE]);
    if (st) begin
      // a start mark always opens a fresh run, dropping any open one
      run_first  = s;
      run_prev   = s;
      run_tally  = '0;
      run_early  = 1'b0;
      run_sensor = id;
      run_pos    = 1;
      return 1'b0;
    end
    if (run_pos == 0) return 1'b0;   // stray reading, no run open

    // up and down compares are separate: jump size zero counts a flat step twice
    if (cur - int'(run_prev) >= jump_i && run_tally != sddc_pkg::TALLY_MAX)
      run_tally++;
    if (int'(run_prev) - cur >= jump_i && run_tally != sddc_pkg::TALLY_MAX)
      run_tally++;
    if (run_pos == 1)
      run_early = (cur - first_i >= int'(reg_copy[sddc_pkg::REG_EARLY_LIM]));
    run_prev = s;
    run_pos++;
    if (run_pos < RUN_LEN) return 1'b0;

    run_pos = 0;
    v.sensor            = run_sensor;
    v.flags[FLAG_INIT]  = first_i > int'(reg_copy[sddc_pkg::REG_INIT_LO]) &&
                          first_i < int'(reg_copy[sddc_pkg::REG_INIT_HI]);
    v.flags[FLAG_EARLY] = run_early;
    v.flags[FLAG_RISE]  = cur - first_i >= int'(reg_copy[sddc_pkg::REG_RISE_LIM]);
    v.flags[FLAG_FINAL] = cur > int'(reg_copy[sddc_pkg::REG_FINAL_LO]) &&
                          cur < int'(reg_copy[sddc_pkg::REG_FINAL_HI]);
    v.flags[FLAG_JUMPS] = {1'b0, run_tally} > reg_copy[sddc_pkg::REG_JUMP_LIM][5:0];
    v.count             = 3'($countones(v.flags));
    return 1'b1;
  endfunction

  // predicts, then offers one reading after a random gap and waits for it
  // to be taken; a typed verdict replaces the predicted one
  task automatic send_reading(input logic [7:0] s, input logic st, input logic [2:0] id,
                              input bit typed, input verdict_t want);
    verdict_t v;
    int       gap;
    int       r;
    if (assess_reading(s, st, id, v) || typed)
      pending_verdicts.push_back(typed ? want : v);
    gap = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r >= 92)      gap = $urandom_range(5, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    s_axis_tuser  <= {id, st};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // lowers valid and waits out every outstanding result plus the pipe depth
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // writes all eight bound registers from next_cfg, block idle
  task automatic load_settings();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= i[sddc_pkg::CFG_ADDR_W-1:0];
      cfg_data_i <= next_cfg[i];
      reg_copy[i] = (i == int'(sddc_pkg::REG_JUMP_LIM)) ? (next_cfg[i] & 8'h3f)
                                                         : next_cfg[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one check run: start mark then readings shaped to land near the bounds;
  // a broken run stops early and is dropped by the next start mark
  task automatic play_run(input bit broken);
    int         len;
    int         style;
    int         slope;
    int         cur;
    logic [7:0] first_rd;
    logic [2:0] id;
    id = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) < 4)
      first_rd = clip(int'(reg_copy[$urandom_range(0, 1) ? sddc_pkg::REG_INIT_HI
                                                         : sddc_pkg::REG_INIT_LO])
                      + jitter(2));
    else
      first_rd = 8'($urandom);
    send_reading(first_rd, 1'b1, id, 1'b0, '0);
    len   = broken ? $urandom_range(1, RUN_LEN - 2) : RUN_LEN - 1;
    style = $urandom_range(0, 3);
    slope = jitter(4) + 1;
    cur   = int'(first_rd);
    for (int k = 2; k <= len + 1; k++) begin
      if (k == 2 && $urandom_range(0, 1))
        // second reading right at the early rise threshold
        cur = int'(first_rd) + int'(reg_copy[sddc_pkg::REG_EARLY_LIM]) + jitter(1);
      else if (k == RUN_LEN && $urandom_range(0, 1)) begin
        // last reading at a final bound or at the overall rise threshold
        case ($urandom_range(0, 2))
          0:       cur = int'(reg_copy[sddc_pkg::REG_FINAL_LO]) + jitter(2);
          1:       cur = int'(reg_copy[sddc_pkg::REG_FINAL_HI]) + jitter(2);
          default: cur = int'(first_rd) + int'(reg_copy[sddc_pkg::REG_RISE_LIM])
                         + jitter(1);
        endcase
      end else begin
        case (style)
          0:       cur += jitter(int'(reg_copy[sddc_pkg::REG_JUMP_SIZE]) + 1);  // noise
          1:       cur += slope;                                                 // drift
          2:       cur = $urandom_range(0, 255);                                 // wild
          default: ;                                                             // flat
        endcase
      end
      cur = int'(clip(cur));
      send_reading(8'(cur), 1'b0, 3'($urandom_range(0, 7)), 1'b0, '0);
    end
    run_items += len + 1;
  endtask

  // ---------------------------------------------------------- opening script
  // strays with no run open, a run dropped by a restart, then one full run
  // on reset bounds that trips all five tests
  script_row_t opening [24] = '{
    '{8'd255, 1'b0, 3'd7, 1'b0, '0},   // stray, sample and sensor at max
    '{8'd0,   1'b0, 3'd0, 1'b0, '0},   // stray, all zero
    '{8'd200, 1'b1, 3'd5, 1'b0, '0},   // opens a run
    '{8'd0,   1'b0, 3'd3, 1'b0, '0},
    '{8'd70,  1'b1, 3'd7, 1'b0, '0},   // restart mid-run, first reading in range
    '{8'd73,  1'b0, 3'd0, 1'b0, '0},   // early rise by 3
    '{8'd0,   1'b0, 3'd0, 1'b0, '0},   // full-swing jumps both ways
    '{8'd255, 1'b0, 3'd0, 1'b0, '0},
    '{8'd0,   1'b0, 3'd0, 1'b0, '0},
    '{8'd255, 1'b0, 3'd0, 1'b0, '0},
    '{8'd85,  1'b0, 3'd1, 1'b0, '0},   // sixth jump, then flat
    '{8'd85,  1'b0, 3'd2, 1'b0, '0},
    '{8'd85,  1'b0, 3'd3, 1'b0, '0},
    '{8'd85,  1'b0, 3'd4, 1'b0, '0},
    '{8'd85,  1'b0, 3'd5, 1'b0, '0},
    '{8'd85,  1'b0, 3'd6, 1'b0, '0},
    '{8'd85,  1'b0, 3'd7, 1'b0, '0},
    '{8'd85,  1'b0, 3'd0, 1'b0, '0},
    '{8'd85,  1'b0, 3'd0, 1'b0, '0},
    '{8'd85,  1'b0, 3'd0, 1'b0, '0},
    '{8'd85,  1'b0, 3'd0, 1'b0, '0},
    '{8'd85,  1'b0, 3'd0, 1'b0, '0},
    '{8'd85,  1'b0, 3'd0, 1'b0, '0},
    '{8'd85,  1'b0, 3'd0, 1'b1, '{3'd7, 5'h1f, 3'd5}}   // every test fails
  };

  // ---------------------------------------------------------------- stimulus
  initial begin
    int phase;
    int r;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[i])
      send_reading(opening[i].sample, opening[i].start, opening[i].sensor,
                   opening[i].typed, opening[i].want);
    drain();

    phase = 0;
    while (run_items < RANDOM_ITEMS) begin
      // order: init lo/hi, final lo/hi, early limit, rise limit, jump size, jump limit
      case (phase)
        0: next_cfg = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        1: next_cfg = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
        2: next_cfg = '{sddc_pkg::INIT_LO_RST, sddc_pkg::INIT_HI_RST,
                        sddc_pkg::FINAL_LO_RST, sddc_pkg::FINAL_HI_RST,
                        sddc_pkg::EARLY_LIM_RST, sddc_pkg::RISE_LIM_RST,
                        sddc_pkg::JUMP_SIZE_RST, 8'h40 | sddc_pkg::JUMP_LIM_RST};
        // jump size zero saturates the tally; a limit of 31 then never trips
        3: next_cfg = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd31};
        4: next_cfg = '{8'd10, 8'd200, 8'd10, 8'd200, 8'd1, 8'd1, 8'd0, 8'd30};
        5: next_cfg = '{8'd30, 8'd220, 8'd40, 8'd210, 8'd1, 8'd3, 8'd1, 8'd12};
        default: begin
          next_cfg[sddc_pkg::REG_INIT_LO]   = 8'($urandom_range(0, 200));
          next_cfg[sddc_pkg::REG_INIT_HI]   =
            clip(int'(next_cfg[sddc_pkg::REG_INIT_LO]) + $urandom_range(0, 90));
          next_cfg[sddc_pkg::REG_FINAL_LO]  = 8'($urandom_range(0, 200));
          next_cfg[sddc_pkg::REG_FINAL_HI]  =
            clip(int'(next_cfg[sddc_pkg::REG_FINAL_LO]) + $urandom_range(0, 40));
          next_cfg[sddc_pkg::REG_EARLY_LIM] = ($urandom_range(0, 7) == 0)
                                              ? 8'($urandom) : 8'($urandom_range(0, 9));
          next_cfg[sddc_pkg::REG_RISE_LIM]  = 8'($urandom_range(0, 20));
          next_cfg[sddc_pkg::REG_JUMP_SIZE] = ($urandom_range(0, 7) == 0)
                                              ? 8'($urandom) : 8'($urandom_range(0, 12));
          // upper two bits are junk the block must drop
          next_cfg[sddc_pkg::REG_JUMP_LIM]  = 8'($urandom_range(0, 40))
                                              | 8'($urandom_range(0, 3) << 6);
        end
      endcase
      load_settings();

      calm = (phase == 2) || (phase % 5 == 4);
      // back-pressure phase: sender streams flat out while the receiver holds off
      if (phase == 2) hold_req = 1'b1;

      repeat (RUNS_PER_SET) begin
        r = $urandom_range(0, 9);
        if (r == 0 && run_pos == 0) begin
          repeat ($urandom_range(1, 3))
            send_reading(8'($urandom), 1'b0, 3'($urandom_range(0, 7)), 1'b0, '0);
        end
        play_run(r == 1);
      end
      drain();
      phase++;
    end
    calm = 1'b0;

    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // ready changes on the falling edge; short stalls mostly, a few long ones
  initial begin
    int r;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm) begin
          r = $urandom_range(0, 99);
          if (r >= 96)      stall_left = $urandom_range(6, 40);
          else if (r >= 75) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  // ------------------------------------------------------------ result check
  // sampled at the rising edge, before the block updates its outputs
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing expected, flags", m_axis_tdata[4:0], 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tuser != want.sensor)
          report_mismatch("checked_sensor", m_axis_tuser, want.sensor);
        if (m_axis_tdata[4:0] != want.flags)
          report_mismatch("test_flags", m_axis_tdata[4:0], want.flags);
        if (m_axis_tdata[7:5] != want.count)
          report_mismatch("evidence_count", m_axis_tdata[7:5], want.count);
      end
    end
  end

  // watchdog well past the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
